// ===== sv/assert_macros.svh =====
// assertion macros for the rtl of the queued color led strobe
// no dependencies; pulled in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define QCLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qcls assertion failed");

// condition must never be true outside reset
`define QCLS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("qcls forbidden condition seen");

`endif

// ===== sv/qcls_pkg.sv =====
// package for the queued color led strobe: widths, codes, pin patterns, tables
// no dependencies; imported by qcls_out_skid and queued_color_led_strobe
package qcls_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int OCC_W      = 4;
    localparam int PINS_W     = 6;
    localparam int COLOR_W    = 3;
    localparam int INTERVAL_W = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [INTERVAL_W-1:0] BASE_INTERVAL_RST = 16'd500;
    localparam logic [INTERVAL_W-1:0] ELAPSED_MAX       = 16'hFFFF;
    localparam logic [ADDR_W-1:0]     ADDR_BASE_INTERVAL = 3'd0;

    // action codes
    localparam logic ACTION_TICK    = 1'b0;
    localparam logic ACTION_ENQUEUE = 1'b1;

    // color codes
    localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd2;
    localparam logic [COLOR_W-1:0] COLOR_TEAL   = 3'd3;
    localparam logic [COLOR_W-1:0] COLOR_PURPLE = 3'd4;

    // active-low pin patterns: [5:4] blue, [3:2] green, [1:0] red
    localparam logic [PINS_W-1:0] PINS_OFF    = 6'h3F;
    localparam logic [PINS_W-1:0] PINS_RED    = 6'h3C;
    localparam logic [PINS_W-1:0] PINS_GREEN  = 6'h33;
    localparam logic [PINS_W-1:0] PINS_BLUE   = 6'h0F;
    localparam logic [PINS_W-1:0] PINS_TEAL   = 6'h03;
    localparam logic [PINS_W-1:0] PINS_PURPLE = 6'h0C;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              fired;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    // unknown codes keep the current levels
    function automatic logic [PINS_W-1:0] pins_for_color(
        input logic [COLOR_W-1:0] c,
        input logic [PINS_W-1:0]  cur
    );
        logic [PINS_W-1:0] p;
        case (c)
            COLOR_RED:    p = PINS_RED;
            COLOR_GREEN:  p = PINS_GREEN;
            COLOR_BLUE:   p = PINS_BLUE;
            COLOR_TEAL:   p = PINS_TEAL;
            COLOR_PURPLE: p = PINS_PURPLE;
            default:      p = cur;
        endcase
        return p;
    endfunction

    // strobe interval by queue occupancy; entry zero is replaced by the base register
    function automatic logic [INTERVAL_W-1:0] occ_interval(input logic [OCC_W-1:0] occ);
        logic [INTERVAL_W-1:0] v;
        case (occ)
            4'd1:    v = 16'd492;
            4'd2:    v = 16'd459;
            4'd3:    v = 16'd426;
            4'd4:    v = 16'd393;
            4'd5:    v = 16'd360;
            4'd6:    v = 16'd327;
            4'd7:    v = 16'd294;
            4'd8:    v = 16'd261;
            4'd9:    v = 16'd228;
            4'd10:   v = 16'd195;
            4'd11:   v = 16'd162;
            4'd12:   v = 16'd129;
            4'd13:   v = 16'd96;
            4'd14:   v = 16'd63;
            4'd15:   v = 16'd20;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/qcls_out_skid.sv =====
// two-deep result buffer: output register plus skid register
// depends on qcls_pkg for result_t
module qcls_out_skid
    import qcls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    take;
    logic    load_out;
    logic    load_skid;

    assign take = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                // skid drains into the output register
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                load_out       = push;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= push_data;
        end
        else if ((!out_valid_reg || take) && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

// ===== sv/queued_color_led_strobe.sv =====
// top level of the queued color led strobe: apb register, color ring, strobe timing
// depends on qcls_pkg, qcls_out_skid and assert_macros.svh
//
//  channel   direction  handshake            beat contents
//  -------   ---------  -------------------  -------------------------------------
//  apb       in/out     psel,penable,pready  base_interval at 0x0 (write and read)
//  in        in         in_valid,in_ready    action, color
//  out       out        out_valid,out_ready  pins, fired, occupancy
//
// one beat in per cycle while in_ready is high; every input beat yields one result beat
// the state update (ring access, compare, increment) is combinational logic
// a two-deep result buffer lets an input beat in while one result waits
// in_ready drops only when both result slots are full
// reset: empty ring, elapsed zero, next phase on, all pins high, base interval 500
module queued_color_led_strobe
    import qcls_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // apb register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // input beats
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [COLOR_W-1:0]  color,
    // result beats
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PINS_W-1:0]   pins,
    output logic                fired,
    output logic [OCC_W-1:0]    occupancy
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);

    // configuration
    logic [INTERVAL_W-1:0] base_interval_reg;
    logic                  cfg_write;

    // strobe state
    logic [COLOR_W-1:0]    queue_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]      wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [INTERVAL_W-1:0] elapsed_reg, elapsed_next;
    logic                  phase_on_reg, phase_on_next;
    logic [PINS_W-1:0]     pin_levels_reg, pin_levels_next;

    logic                  in_fire;
    logic                  enqueue;
    logic [IDX_W-1:0]      occ_now;
    logic [IDX_W-1:0]      occ_after;
    logic [INTERVAL_W-1:0] interval;
    logic [INTERVAL_W-1:0] elapsed_inc;
    logic                  fire_now;
    logic [IDX_W-1:0]      wr_adv;
    logic [COLOR_W-1:0]    head_color;
    result_t               res;
    result_t               out_data;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_count(
        input logic [IDX_W-1:0] w,
        input logic [IDX_W-1:0] r
    );
        logic [IDX_W:0] d;
        if (w >= r)
        begin
            d = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            d = {1'b0, w} + DEPTH_EXT - {1'b0, r};
        end
        return d[IDX_W-1:0];
    endfunction

    // ---------------- apb register ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_BASE_INTERVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_interval_reg <= BASE_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            base_interval_reg <= pwdata[INTERVAL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_BASE_INTERVAL)
        begin
            prdata = DATA_W'(base_interval_reg);
        end
    end

    // ---------------- strobe update ----------------
    assign in_fire = in_valid && in_ready;
    assign enqueue = (action == ACTION_ENQUEUE);

    assign occ_now     = ring_count(wr_idx_reg, rd_idx_reg);
    // empty ring uses the register, otherwise the shrinking table
    assign interval    = (occ_now == '0) ? base_interval_reg
                                         : occ_interval(OCC_W'(occ_now));
    // saturating tick counter
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign fire_now    = !enqueue && (elapsed_inc > interval);
    assign wr_adv      = advance(wr_idx_reg);
    assign head_color  = queue_reg[rd_idx_reg];

    always_comb
    begin
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        elapsed_next    = elapsed_reg;
        phase_on_next   = phase_on_reg;
        pin_levels_next = pin_levels_reg;
        if (enqueue)
        begin
            wr_idx_next = wr_adv;
            // full ring drops its oldest color
            if (wr_adv == rd_idx_reg)
            begin
                rd_idx_next = advance(rd_idx_reg);
            end
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (fire_now)
            begin
                if (phase_on_reg)
                begin
                    if (occ_now != '0)
                    begin
                        rd_idx_next     = advance(rd_idx_reg);
                        pin_levels_next = pins_for_color(head_color, pin_levels_reg);
                    end
                    else
                    begin
                        pin_levels_next = pins_for_color(color, pin_levels_reg);
                    end
                end
                else
                begin
                    pin_levels_next = PINS_OFF;
                end
                phase_on_next = !phase_on_reg;
                elapsed_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            elapsed_reg    <= '0;
            phase_on_reg   <= 1'b1;
            pin_levels_reg <= PINS_OFF;
        end
        else if (in_fire)
        begin
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            elapsed_reg    <= elapsed_next;
            phase_on_reg   <= phase_on_next;
            pin_levels_reg <= pin_levels_next;
        end
    end

    // ring storage, no reset: only written entries are ever read
    always_ff @(posedge clk)
    begin
        if (in_fire && enqueue)
        begin
            queue_reg[wr_idx_reg] <= color;
        end
    end

    // ---------------- result beat ----------------
    assign occ_after     = ring_count(wr_idx_next, rd_idx_next);
    assign res.pins      = pin_levels_next;
    assign res.fired     = fire_now;
    assign res.occupancy = OCC_W'(occ_after);

    qcls_out_skid u_out_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire),
        .push_data  (res),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign pins      = out_data.pins;
    assign fired     = out_data.fired;
    assign occupancy = out_data.occupancy;

    // ---------------- checks ----------------
    // a stalled input means both result slots hold data
    `QCLS_ASSERT_NEVER(a_stall_without_result, clk, rst_n, !in_ready && !out_valid)
    // the ring never reports a depth it cannot hold
    `QCLS_ASSERT_NEVER(a_occ_in_range, clk, rst_n, OCC_W'(occ_now) > OCC_W'(QUEUE_DEPTH - 1))
    // waiting for the on phase means every pin is dark
    `QCLS_ASSERT(a_off_phase_dark, clk, rst_n, phase_on_reg |-> pin_levels_reg == PINS_OFF)
    // a strobe edge restarts the tick count
    `QCLS_ASSERT(a_fire_clears, clk, rst_n, in_fire && fire_now |=> elapsed_reg == '0)

endmodule
